@@ sv/hcq_pkg.sv @@
// hcq_pkg: shared constants, types and state codes for the histogram column quantile block
// no dependencies; imported by hcq_scan_unit and histogram_column_quantile
`timescale 1ns / 1ps

package hcq_pkg;

    localparam int MAX_BINS   = 4096;
    localparam int COUNT_BITS = 16;

    localparam int IDX_W      = $clog2(MAX_BINS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int PCT_W      = 7;
    localparam int TOTAL_W    = COUNT_BITS + IDX_W;
    localparam int TARGET_W   = TOTAL_W + PCT_W;
    localparam int SCALED_W   = COUNT_BITS + PCT_W;

    localparam logic [PCT_W-1:0] PERCENT_RESET = PCT_W'(50);
    localparam logic [PCT_W-1:0] PERCENT_MAX   = PCT_W'(100);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PREP,
        ST_READ,
        ST_DRAIN
    } t_state;

    // tag that travels with each bin read out of the store
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_scan_tag;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] bin;
    } t_scan_res;

endpackage

@@ sv/hcq_scan_unit.sv @@
// hcq_scan_unit: shared scale, accumulate and compare unit for the percentile scan
// depends on hcq_pkg
`timescale 1ns / 1ps

module hcq_scan_unit
    import hcq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [TARGET_W-1:0]   i_target,
    input  t_scan_tag             i_tag,
    input  logic [COUNT_BITS-1:0] i_data,
    output t_scan_res             o_res
);

    t_scan_tag             r_tag;
    logic [SCALED_W-1:0]   r_scaled;
    logic [TARGET_W-1:0]   r_target;
    logic [TARGET_W-1:0]   r_acc;
    logic                  r_found;
    logic [IDX_W-1:0]      r_bin;
    t_scan_res             r_res;

    logic [TARGET_W-1:0]   n_acc;
    logic                  hit;
    logic                  first_hit;

    assign n_acc     = r_acc + TARGET_W'(r_scaled);
    assign hit       = (n_acc >= r_target);
    assign first_hit = r_tag.vld && hit && !r_found;

    // stage 1: scale the bin count by 100
    always_ff @(posedge i_clk) begin
        r_scaled <= SCALED_W'(i_data) * SCALED_W'(100);
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    // stage 2: running sum and first-hit capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_found  <= 1'b0;
            r_res    <= '0;
            r_target <= '0;
            r_bin    <= '0;
        end else begin
            r_res.done <= r_tag.vld && r_tag.last;
            if (i_start) begin
                r_target <= i_target;
                r_acc    <= '0;
                r_found  <= 1'b0;
                r_bin    <= '0;
            end else if (r_tag.vld) begin
                r_acc <= n_acc;
                if (first_hit) begin
                    r_found <= 1'b1;
                    r_bin   <= r_tag.idx;
                end
            end
            if (r_tag.vld && r_tag.last) begin
                r_res.bin <= first_hit ? r_tag.idx : r_bin;
            end
        end
    end

    assign o_res = r_res;

endmodule

@@ sv/histogram_column_quantile.sv @@
// histogram_column_quantile: top level, bin store, column sequencer and result register
// depends on hcq_pkg and hcq_scan_unit
`timescale 1ns / 1ps
//
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_bin_count[15:0], i_last_in_column
// result    out        o_valid / i_ready    o_quantile_bin[11:0], o_bins_seen[12:0],
//                                           o_empty_column, o_overflow
// config    in         i_cfg_we             i_cfg_wdata[6:0] (percent)
//
// each accepted bin item is stored while the store has room (later ones only set
// o_overflow); o_ready stays high while bins load. after the last bin of a column
// the block drops o_ready and scans the store: a start step, one read per stored
// bin through the single store read port, then a drain through the read register
// and the scale and accumulate stages of the shared accumulate and compare unit
// the scan waits to start until the previous result has been taken
// reset is synchronous and active low; the store needs no clearing pass

module histogram_column_quantile
    import hcq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COUNT_BITS-1:0] i_bin_count,
    input  logic                  i_last_in_column,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [IDX_W-1:0]      o_quantile_bin,
    output logic [CNT_W-1:0]      o_bins_seen,
    output logic                  o_empty_column,
    output logic                  o_overflow,
    input  logic                  i_cfg_we,
    input  logic [PCT_W-1:0]      i_cfg_wdata
);

    // bin store, written while loading and read during the scan
    logic [COUNT_BITS-1:0] r_bin_store [MAX_BINS];

    t_state                r_state, n_state;
    logic [PCT_W-1:0]      r_percent;
    logic [CNT_W-1:0]      r_wr_idx;
    logic [TOTAL_W-1:0]    r_total;
    logic                  r_ovf;
    logic [CNT_W-1:0]      r_rd_idx, n_rd_idx;

    logic [COUNT_BITS-1:0] r_rd_data;
    t_scan_tag             r_rd_tag;

    logic                  r_out_valid;
    logic [IDX_W-1:0]      r_out_bin;
    logic [CNT_W-1:0]      r_out_seen;
    logic                  r_out_empty;
    logic                  r_out_ovf;

    logic                  accept;
    logic                  store_ok;
    logic                  rd_en;
    logic                  rd_last;
    logic                  scan_start;
    logic [PCT_W-1:0]      pct_sat;
    logic [TARGET_W-1:0]   target;
    t_scan_res             scan_res;

    assign accept   = i_valid && o_ready;
    assign store_ok = (r_wr_idx < CNT_W'(MAX_BINS));
    assign rd_last  = (r_rd_idx == r_wr_idx - CNT_W'(1));

    // percent above 100 behaves as 100
    assign pct_sat = (r_percent > PERCENT_MAX) ? PERCENT_MAX : r_percent;
    assign target  = TARGET_W'(pct_sat) * TARGET_W'(r_total);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_rd_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_idx <= n_rd_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_rd_idx   = r_rd_idx;
        o_ready    = 1'b0;
        rd_en      = 1'b0;
        scan_start = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_ready  = 1'b1;
                n_rd_idx = '0;
                if (accept && i_last_in_column) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                // hold until the previous result has left the output register
                if (!r_out_valid) begin
                    scan_start = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                rd_en    = 1'b1;
                n_rd_idx = r_rd_idx + CNT_W'(1);
                if (rd_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (scan_res.done) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // store write and read port
    always_ff @(posedge i_clk) begin
        if (accept && store_ok) begin
            r_bin_store[r_wr_idx[IDX_W-1:0]] <= i_bin_count;
        end
        if (rd_en) begin
            r_rd_data <= r_bin_store[r_rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
        end else begin
            r_rd_tag.vld  <= rd_en;
            r_rd_tag.last <= rd_en && rd_last;
            r_rd_tag.idx  <= r_rd_idx[IDX_W-1:0];
        end
    end

    // column bookkeeping and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_percent <= PERCENT_RESET;
            r_wr_idx  <= '0;
            r_total   <= '0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_percent <= i_cfg_wdata;
            end
            if (accept) begin
                if (store_ok) begin
                    r_wr_idx <= r_wr_idx + CNT_W'(1);
                    r_total  <= r_total + TOTAL_W'(i_bin_count);
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (r_state == ST_DRAIN && scan_res.done) begin
                r_wr_idx <= '0;
                r_total  <= '0;
                r_ovf    <= 1'b0;
            end
        end
    end

    hcq_scan_unit u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (scan_start),
        .i_target (target),
        .i_tag    (r_rd_tag),
        .i_data   (r_rd_data),
        .o_res    (scan_res)
    );

    // result register, loaded at the end of the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DRAIN && scan_res.done) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (r_state == ST_DRAIN && scan_res.done) begin
            r_out_bin   <= scan_res.bin;
            r_out_seen  <= r_wr_idx;
            r_out_empty <= (r_total == '0);
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_quantile_bin = r_out_bin;
    assign o_bins_seen    = r_out_seen;
    assign o_empty_column = r_out_empty;
    assign o_overflow     = r_out_ovf;

endmodule

@@ sim/tb_histogram_column_quantile.sv @@
// tb_histogram_column_quantile: self-checking testbench for the histogram column quantile block
// depends on hcq_pkg and histogram_column_quantile; predicts each column result in place
`timescale 1ns / 1ps

module tb_histogram_column_quantile;
    import hcq_pkg::*;

    localparam int STALL_LIMIT   = 40000;   // cycles with no item moving on either channel
    localparam int SETTLE_CYCLES = 16;      // pad after the last result before a config write
    localparam int RANDOM_ITEMS  = 1650;
    localparam int NUM_PHASES    = 5;
    localparam int REPORT_MAX    = 10;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [PCT_W-1:0]      PCT_TOP   = '1;

    typedef struct packed {
        logic [IDX_W-1:0] bin;
        logic [CNT_W-1:0] seen;
        logic             empty;
        logic             ovf;
    } t_quantile_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [COUNT_BITS-1:0] i_bin_count;
    logic                  i_last_in_column;
    logic                  o_valid;
    logic                  i_ready;
    logic [IDX_W-1:0]      o_quantile_bin;
    logic [CNT_W-1:0]      o_bins_seen;
    logic                  o_empty_column;
    logic                  o_overflow;
    logic                  i_cfg_we;
    logic [PCT_W-1:0]      i_cfg_wdata;

    histogram_column_quantile u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_bin_count      (i_bin_count),
        .i_last_in_column (i_last_in_column),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_quantile_bin   (o_quantile_bin),
        .o_bins_seen      (o_bins_seen),
        .o_empty_column   (o_empty_column),
        .o_overflow       (o_overflow),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    // predictor copy of the column being loaded and of the percent register
    logic [COUNT_BITS-1:0] col_bins [MAX_BINS];
    int unsigned           col_len;
    longint unsigned       col_sum;
    bit                    col_dropped;
    logic [PCT_W-1:0]      pct_model;

    t_quantile_result quantile_q [$];
    t_quantile_result want_r;
    int               fail_count;
    bit               idle_on;
    int unsigned      idle_run;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // most gaps are zero or short, a few are long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [COUNT_BITS-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return '0;
        if (r < 40)
            return COUNT_BITS'($urandom_range(1, 15));
        if (r < 50)
            return COUNT_MAX;
        return COUNT_BITS'($urandom);
    endfunction

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(1, 6);
        if (r < 95)
            return $urandom_range(7, 40);
        return $urandom_range(41, 300);
    endfunction

    // first bin whose running sum reaches the saturated percent of the total
    function automatic t_quantile_result predict_quantile();
        t_quantile_result r;
        longint unsigned  pct;
        longint unsigned  target;
        longint unsigned  run;
        int unsigned      k;
        bit               hit;
        pct    = (pct_model > PERCENT_MAX) ? 64'(PERCENT_MAX) : 64'(pct_model);
        target = pct * col_sum;
        run    = 0;
        hit    = 1'b0;
        r.bin  = '0;
        for (k = 0; k < col_len && !hit; k++) begin
            run += 64'(col_bins[k]);
            if (100 * run >= target) begin
                r.bin = IDX_W'(k);
                hit   = 1'b1;
            end
        end
        r.seen  = CNT_W'(col_len);
        r.empty = (col_sum == 0);
        r.ovf   = col_dropped;
        return r;
    endfunction

    // predictor: follows every accepted bin item
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            if (col_len < MAX_BINS) begin
                col_bins[col_len] = i_bin_count;
                col_len++;
                col_sum += 64'(i_bin_count);
            end else begin
                col_dropped = 1'b1;
            end
            if (i_last_in_column) begin
                quantile_q  = {quantile_q, predict_quantile()};
                col_len     = 0;
                col_sum     = 0;
                col_dropped = 1'b0;
            end
        end
    end

    // checker: each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (quantile_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result at %0t: bin %0d seen %0d empty %0b ovf %0b",
                             $time, o_quantile_bin, o_bins_seen, o_empty_column, o_overflow);
            end else begin
                want_r = quantile_q.pop_front();
                if (o_quantile_bin !== want_r.bin || o_bins_seen !== want_r.seen ||
                    o_empty_column !== want_r.empty || o_overflow !== want_r.ovf) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $write("mismatch at %0t (expected/actual): bin %0d/%0d ", $time,
                               want_r.bin, o_quantile_bin);
                        $display("seen %0d/%0d empty %0b/%0b ovf %0b/%0b",
                                 want_r.seen, o_bins_seen, want_r.empty, o_empty_column,
                                 want_r.ovf, o_overflow);
                    end
                end
            end
        end
    end

    // result side: random stalls of i_ready
    initial begin : result_sink
        int unsigned n;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = pick_gap();
            if (n != 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // one bin item; valid stays high into the next item when no gap follows
    task automatic send_bin(input logic [COUNT_BITS-1:0] count, input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_bin_count      <= count;
        i_last_in_column <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_random_column(input int unsigned len);
        int unsigned i;
        for (i = 0; i < len; i++)
            send_bin(pick_count(), i == len - 1);
    endtask

    // stop sending, let every expected result arrive, then let the block settle
    task automatic drain_results();
        i_valid <= 1'b0;
        // wait for the clock so the predictor has queued the last column
        @(posedge i_clk);
        while (quantile_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_percent(input logic [PCT_W-1:0] pct);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= pct;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pct_model    = pct;
    endtask

    // percent still at its reset value: single bins, empty column, exact threshold
    task automatic test_reset_median();
        send_bin('0, 1'b1);
        send_bin(COUNT_MAX, 1'b1);
        send_bin('0, 1'b0);
        send_bin('0, 1'b1);
        send_bin(COUNT_BITS'(1), 1'b0);
        send_bin(COUNT_BITS'(1), 1'b0);
        send_bin(COUNT_BITS'(1), 1'b0);
        send_bin(COUNT_BITS'(1), 1'b1);
        send_bin(COUNT_MAX, 1'b0);
        send_bin('0, 1'b0);
        send_bin(COUNT_MAX, 1'b1);
        send_bin('0, 1'b0);
        send_bin('0, 1'b0);
        send_bin(COUNT_BITS'(5), 1'b1);
    endtask

    // percent zero, exactly 100, and above 100 where it saturates
    task automatic test_percent_limits();
        int unsigned p;
        logic [PCT_W-1:0] pcts [3];
        pcts[0] = '0;
        pcts[1] = PERCENT_MAX;
        pcts[2] = PCT_TOP;
        for (p = 0; p < 3; p++) begin
            set_percent(pcts[p]);
            send_bin('0, 1'b0);
            send_bin(COUNT_BITS'(3), 1'b0);
            send_bin('0, 1'b0);
            send_bin(COUNT_BITS'(4), 1'b0);
            send_bin('0, 1'b1);
        end
    endtask

    // a column that fills the store exactly, then one that runs past it
    task automatic test_store_full();
        int unsigned i;
        set_percent(PERCENT_MAX);
        for (i = 0; i < MAX_BINS; i++)
            send_bin((i == MAX_BINS - 1) ? COUNT_MAX : pick_count(), i == MAX_BINS - 1);
        set_percent(PCT_W'($urandom_range(1, 99)));
        // dropped bins carry full counts, they must not reach the total
        for (i = 0; i < MAX_BINS + 6; i++)
            send_bin((i < MAX_BINS) ? pick_count() : COUNT_MAX, i == MAX_BINS + 5);
    endtask

    // sender holds off until the block has returned everything
    task automatic test_drain_pause();
        int unsigned c;
        set_percent(PCT_W'($urandom_range(1, 99)));
        for (c = 0; c < 8; c++) begin
            send_random_column(pick_len());
            drain_results();
        end
    endtask

    task automatic test_random_columns();
        int unsigned ph;
        int unsigned sent;
        int unsigned len;
        logic [PCT_W-1:0] pct;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    pct = PERCENT_RESET;
                end
                1: begin
                    pct = PCT_W'($urandom_range(0, 127));
                end
                2: begin
                    pct = PCT_W'($urandom_range(101, 127));
                end
                3: begin
                    pct = PCT_W'($urandom_range(1, 9));
                end
                default: begin
                    pct = PCT_W'($urandom_range(10, 99));
                end
            endcase
            set_percent(pct);
            // last phase runs with no idling on either side
            idle_on = (ph != NUM_PHASES - 1);
            sent = 0;
            while (sent < RANDOM_ITEMS / NUM_PHASES) begin
                len = pick_len();
                send_random_column(len);
                sent += len;
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_bin_count      <= '0;
        i_last_in_column <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        col_len     = 0;
        col_sum     = 0;
        col_dropped = 1'b0;
        pct_model   = PERCENT_RESET;
        fail_count  = 0;
        idle_on     = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_median();
        test_percent_limits();
        test_store_full();
        test_drain_pause();
        test_random_columns();

        drain_results();
        if (fail_count == 0 && quantile_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
